@@ src/blc_pkg.sv @@
// ----------------------------------------------------------------------------
// blc_pkg
// shared widths, level codes, register indexes and threshold record for the
// battery level classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blc_pkg;

  // field widths
  localparam int SAMPLE_W  = 12;
  localparam int THR_W     = 12;
  localparam int LEVEL_W   = 2;
  localparam int ACC_W     = 16;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  // samples per block
  localparam int BLOCK_LEN_DEF = 10;

  // nominal thresholds and half band
  localparam int MID_NOMINAL = 2350;
  localparam int LOW_NOMINAL = 2240;
  localparam int BAND_HALF   = 15;

  // level codes
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENTER      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_EXIT_UPPER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_ENTER_LOWER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ENTER       = 2'd3;

  typedef struct packed {
    logic [THR_W-1:0] high_enter;
    logic [THR_W-1:0] mid_exit_upper;
    logic [THR_W-1:0] mid_enter_lower;
    logic [THR_W-1:0] low_enter;
  } thresh_t;

  localparam thresh_t THRESH_RESET = '{
    high_enter:      THR_W'(MID_NOMINAL + BAND_HALF),
    mid_exit_upper:  THR_W'(MID_NOMINAL - BAND_HALF),
    mid_enter_lower: THR_W'(LOW_NOMINAL + BAND_HALF),
    low_enter:       THR_W'(LOW_NOMINAL - BAND_HALF)
  };

endpackage

`default_nettype wire

@@ src/blc_classify.sv @@
// ----------------------------------------------------------------------------
// blc_classify
// block sum to floor mean by reciprocal multiply, then level with hysteresis
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blc_classify import blc_pkg::*; #(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic [ACC_W-1:0]    sum,
  input  wire thresh_t             thresh,
  input  wire logic [LEVEL_W-1:0]  prev_level,
  output logic      [SAMPLE_W-1:0] average,
  output logic      [LEVEL_W-1:0]  level
);

  // exact floor division for any dividend below 2**ACC_W
  localparam int DIV_SHIFT = ACC_W + $clog2(BLOCK_LEN);
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int PROD_W    = ACC_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'(((64'd1 << DIV_SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

  logic [PROD_W-1:0] prod;

  assign prod    = PROD_W'(sum) * PROD_W'(DIV_MULT);
  assign average = prod[DIV_SHIFT +: SAMPLE_W];

  // first test that holds wins, dead band keeps the old level
  always_comb begin
    if (average >= thresh.high_enter) begin
      level = LEVEL_HIGH;
    end else if (average >= thresh.mid_enter_lower && average <= thresh.mid_exit_upper) begin
      level = LEVEL_MID;
    end else if (average <= thresh.low_enter) begin
      level = LEVEL_LOW;
    end else begin
      level = prev_level;
    end
  end

endmodule

`default_nettype wire

@@ src/battery_level_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// battery_level_classifier_unit
// averages blocks of battery adc samples and reports a hysteretic level
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  s_*      | in        | s_tvalid / s_tready   | s_tdata[11:0] sample
//  m_*      | out       | m_tvalid / m_tready   | m_tdata[1:0] level,
//           |           |                       | m_tdata[13:2] average
//  cfg_*    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data[11:0]
//
//  one sample request per cycle is taken at full rate, but a request that closes
//  a block waits while the sum register is full and its result stalls; the
//  accumulator adder is the only per-sample loop; a block's closing request
//  passes the input register, accumulator/sum register and result register
//  rst is synchronous; it clears the block, sets level to high and loads the
//  default thresholds
//  a stalled result holds in the output register while samples that do not
//  close a block keep flowing in; cfg_ready is always high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module battery_level_classifier_unit import blc_pkg::*; #(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // sample stream in
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,    // [11:0] sample
  // result stream out
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,    // [1:0] level, [13:2] average
  // threshold writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]     cfg_data
);

  // input register
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;

  // running block state
  logic [ACC_W-1:0]    acc;
  logic [CNT_W-1:0]    count;
  logic [ACC_W-1:0]    acc_sum;
  logic                last_item;
  logic                consume;

  // closed block waiting for classification
  logic                sum_valid;
  logic [ACC_W-1:0]    sum_reg;
  logic                fire;

  // result register and level state
  logic [SAMPLE_W-1:0] out_avg;
  logic [LEVEL_W-1:0]  current_level;
  logic [SAMPLE_W-1:0] cls_avg;
  logic [LEVEL_W-1:0]  cls_level;

  thresh_t             thresh;

  // the request that closes a block needs a free sum register
  assign acc_sum   = acc + ACC_W'(in_sample);
  assign last_item = (count == CNT_W'(BLOCK_LEN - 1));
  assign fire      = sum_valid && (!m_tvalid || m_tready);
  assign consume   = in_valid && (!last_item || !sum_valid || fire);
  assign s_tready  = !in_valid || consume;
  assign cfg_ready = 1'b1;

  assign m_tdata   = {{(M_TDATA_W - SAMPLE_W - LEVEL_W){1'b0}}, out_avg, current_level};

  blc_classify #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_classify (
    .sum        (sum_reg),
    .thresh     (thresh),
    .prev_level (current_level),
    .average    (cls_avg),
    .level      (cls_level)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      acc           <= '0;
      count         <= '0;
      sum_valid     <= 1'b0;
      m_tvalid      <= 1'b0;
      current_level <= LEVEL_HIGH;
      thresh        <= THRESH_RESET;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end

      if (consume) begin
        if (last_item) begin
          acc   <= '0;
          count <= '0;
        end else begin
          acc   <= acc_sum;
          count <= count + CNT_W'(1);
        end
      end

      if (consume && last_item) begin
        sum_valid <= 1'b1;
      end else if (fire) begin
        sum_valid <= 1'b0;
      end

      // level is state and output at once
      if (fire) begin
        m_tvalid      <= 1'b1;
        current_level <= cls_level;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HIGH_ENTER:      thresh.high_enter      <= cfg_data;
          REG_MID_EXIT_UPPER:  thresh.mid_exit_upper  <= cfg_data;
          REG_MID_ENTER_LOWER: thresh.mid_enter_lower <= cfg_data;
          REG_LOW_ENTER:       thresh.low_enter       <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata[SAMPLE_W-1:0];
    end
    if (consume && last_item) begin
      sum_reg <= acc_sum;
    end
    if (fire) begin
      out_avg <= cls_avg;
    end
  end

  // closing a block restarts the accumulator from zero
  a_block_restart: assert property (@(posedge clk) disable iff (rst)
    (consume && last_item) |=> (acc == '0 && count == '0 && sum_valid))
    else $error("block close did not restart accumulator");

  // a new result only appears after a closed block was waiting
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(sum_valid))
    else $error("result without a closed block");

  // the classified level is presented with its result
  a_level_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> (m_tvalid && m_tdata[LEVEL_W-1:0] == $past(cls_level)))
    else $error("level not presented with result");

  // the open block never reaches its full length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    consume |=> (count < CNT_W'(BLOCK_LEN) || $past(count) == CNT_W'(BLOCK_LEN - 1)))
    else $error("sample count overran block length");

endmodule

`default_nettype wire
